>>> src/csdm_pkg.sv
// shared constants and types for the checked signed divider
package csdm_pkg;

	// width of every operand and answer field on the ports
	localparam int FIELD_WIDTH = 64;

	// default internal arithmetic width
	localparam int DATA_WIDTH_DEF = 64;

	// request type codes
	localparam logic REQ_QUOT = 1'b0;
	localparam logic REQ_REM  = 1'b1;

	// control group that travels with each item down the divider pipeline
	typedef struct packed {
		logic valid;
		logic op;
		logic neg_a;
		logic neg_b;
		logic zero;
	} csdm_ctl_t;

	// one result item
	typedef struct packed {
		logic [FIELD_WIDTH-1:0] answer;
		logic                   div_by_zero;
	} csdm_rsp_t;

endpackage

>>> src/csdm_req_if.sv
// request channel: operation selector and two signed operands
interface csdm_req_if;
	import csdm_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [FIELD_WIDTH-1:0] dividend;
	logic signed [FIELD_WIDTH-1:0] divisor;

	modport source (output valid, output req_type, output dividend, output divisor,
		input ready);
	modport sink (input valid, input req_type, input dividend, input divisor,
		output ready);
endinterface

>>> src/csdm_rsp_if.sv
// result channel: answer and divide-by-zero flag
interface csdm_rsp_if;
	import csdm_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [FIELD_WIDTH-1:0] answer;
	logic                          div_by_zero;

	modport source (output valid, output answer, output div_by_zero, input ready);
	modport sink (input valid, input answer, input div_by_zero, output ready);
endinterface

>>> src/csdm_div_stage.sv
// one registered restoring-division step: one quotient bit per stage
module csdm_div_stage #(
	parameter int W = csdm_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  csdm_pkg::csdm_ctl_t ctl_i,
	input  logic [W-1:0]       rem_i,
	input  logic [W-1:0]       quo_i,
	input  logic [W-1:0]       mb_i,
	output csdm_pkg::csdm_ctl_t ctl_o,
	output logic [W-1:0]       rem_o,
	output logic [W-1:0]       quo_o,
	output logic [W-1:0]       mb_o
);
	import csdm_pkg::*;

	logic [W-1:0] trial;
	logic [W-1:0] diff;
	logic         fits;

	// partial remainder stays below the divisor magnitude, so its top bit is free
	assign trial = {rem_i[W-2:0], quo_i[W-1]};
	assign fits  = (trial >= mb_i);
	assign diff  = trial - mb_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (advance) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_o <= fits ? diff : trial;
			quo_o <= {quo_i[W-2:0], fits};
			mb_o  <= mb_i;
		end
	end
endmodule

>>> src/checked_signed_divide_modulo.sv
// top level of the pipelined checked signed divider with remainder
//
// Signed divide / modulo at DATA_WIDTH bits (8 to 64), one request per clock
// cycle sustained while the output buffer is not full. The operands are the
// low DATA_WIDTH bits of dividend and divisor, sign-extended; the answer is
// computed at DATA_WIDTH bits and sign-extended to 64. Quotients truncate
// toward zero, remainders carry the sign of the dividend, a zero divisor
// gives answer 0 with div_by_zero set, and the most negative value divided
// by minus one wraps to itself. On the way to the result, one stage takes
// the operand magnitudes, DATA_WIDTH restoring division stages each settle
// one quotient bit with one DATA_WIDTH-bit compare and subtract, and the
// sign fixup is written into the output register. A two-entry output buffer
// lets the pipeline keep taking requests while a finished result waits; the
// whole pipeline holds only once that buffer is full. No reset sweep, no
// configuration.
module checked_signed_divide_modulo #(
	parameter int DATA_WIDTH = csdm_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	csdm_req_if.sink   req,
	csdm_rsp_if.source rsp
);
	import csdm_pkg::*;

	localparam int W = DATA_WIDTH;

	// pipeline-wide advance: every stage moves together
	logic advance;

	// stage 1: operand magnitudes and flags
	logic signed [W-1:0] a_in;
	logic signed [W-1:0] b_in;
	csdm_ctl_t           ctl_in;

	// index 0 is the stage 1 register, index k is after k division steps
	csdm_ctl_t    ctl_s [W+1];
	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] quo_s [W+1];
	logic [W-1:0] mb_s  [W+1];

	// final fixup feeding the output buffer
	logic [W-1:0] mag_res;
	logic         neg_res;
	logic [W-1:0] res;
	csdm_rsp_t    fin;
	logic         push;
	logic         pop;

	// output buffer: head register drives the port, skid catches one more
	csdm_rsp_t out_q;
	logic      out_valid_q;
	csdm_rsp_t skid_q;
	logic      skid_valid_q;

	// hold everything only when both output entries are occupied
	assign advance   = !skid_valid_q;
	assign req.ready = advance;

	// narrow the operands to the working width, keeping their signs
	assign a_in = req.dividend[W-1:0];
	assign b_in = req.divisor[W-1:0];

	always_comb begin
		ctl_in.valid = req.valid;
		ctl_in.op    = req.req_type;
		ctl_in.neg_a = a_in[W-1];
		ctl_in.neg_b = b_in[W-1];
		ctl_in.zero  = (b_in == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (advance) begin
			ctl_s[0] <= ctl_in;
		end
	end

	// magnitudes; the most negative value maps to 2^(W-1) unsigned
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= '0;
			quo_s[0] <= a_in[W-1] ? W'(-a_in) : W'(a_in);
			mb_s[0]  <= b_in[W-1] ? W'(-b_in) : W'(b_in);
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < W; k++) begin : g_step
		csdm_div_stage #(
			.W (W)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.ctl_i   (ctl_s[k]),
			.rem_i   (rem_s[k]),
			.quo_i   (quo_s[k]),
			.mb_i    (mb_s[k]),
			.ctl_o   (ctl_s[k+1]),
			.rem_o   (rem_s[k+1]),
			.quo_o   (quo_s[k+1]),
			.mb_o    (mb_s[k+1])
		);
	end

	// pick quotient or remainder and restore the sign
	always_comb begin
		case (ctl_s[W].op)
			REQ_QUOT: begin
				mag_res = quo_s[W];
				neg_res = ctl_s[W].neg_a ^ ctl_s[W].neg_b;
			end
			REQ_REM: begin
				mag_res = rem_s[W];
				neg_res = ctl_s[W].neg_a;
			end
			default: begin
				mag_res = quo_s[W];
				neg_res = 1'b0;
			end
		endcase
		res = neg_res ? (W'(0) - mag_res) : mag_res;
		if (ctl_s[W].zero) begin
			fin.answer      = '0;
			fin.div_by_zero = 1'b1;
		end else begin
			fin.answer      = FIELD_WIDTH'(signed'(res));
			fin.div_by_zero = 1'b0;
		end
	end

	assign push = advance && ctl_s[W].valid;
	assign pop  = out_valid_q && rsp.ready;

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			// head is free: refill from skid first, else from the pipeline
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output buffer data
	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : fin;
		end else if (push) begin
			skid_q <= fin;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.answer      = out_q.answer;
	assign rsp.div_by_zero = out_q.div_by_zero;
endmodule
